// ===== rtl/kfq_pkg.sv =====
package kfq_pkg;

	localparam int MAX_KEYS_DEF  = 64;
	localparam int FRAC_BITS_DEF = 14;

	localparam int KEY_COUNT_W = 7;
	localparam int SLOT_W      = 6;
	localparam int TIME_W      = 24;
	localparam int QUAT_W      = 16;
	localparam int QUAT_PACK_W = 4 * QUAT_W;
	localparam int MAT_W       = 16;
	localparam int T_FRAC      = 16;
	localparam int T_W         = T_FRAC + 1;
	localparam int T_ONE       = 1 << T_FRAC;

	// Reciprocal of 100 scaled by 2^32, exact for every 24-bit dividend.
	localparam logic [25:0] DIV100_MUL   = 26'd42949673;
	localparam int          DIV100_SHIFT = 32;
	localparam int          DIV100_PW    = TIME_W + 26;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic [SLOT_W-1:0]        key_slot;
		logic [TIME_W-1:0]        key_frame_time;
		logic signed [QUAT_W-1:0] quat_x_in;
		logic signed [QUAT_W-1:0] quat_y_in;
		logic signed [QUAT_W-1:0] quat_z_in;
		logic signed [QUAT_W-1:0] quat_w_in;
	} item_t;

	typedef struct packed {
		logic signed [MAT_W-1:0] m00;
		logic signed [MAT_W-1:0] m01;
		logic signed [MAT_W-1:0] m02;
		logic signed [MAT_W-1:0] m10;
		logic signed [MAT_W-1:0] m11;
		logic signed [MAT_W-1:0] m12;
		logic signed [MAT_W-1:0] m20;
		logic signed [MAT_W-1:0] m21;
		logic signed [MAT_W-1:0] m22;
		logic [TIME_W-1:0]       frame_used;
		logic                    zero_norm;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LAST_RD,
		ST_LAST_WT,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SEG_CUR,
		ST_SEG_NXT,
		ST_SEG_LATCH,
		ST_T_SETUP,
		ST_T_DIV,
		ST_BLEND,
		ST_SQUARE,
		ST_SQRT,
		ST_UDIV_INIT,
		ST_UDIV_STEP,
		ST_PROD,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/kfq_ram.sv =====
module kfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/keyframe_quat_nlerp_to_matrix_top.sv =====
// Keyframe quaternion interpolator with rotation matrix output.
// Requests arrive on item_valid/item_ready as kfq_pkg::item_t. A load request
// writes one keyframe (time and quaternion) into the key memories and gives
// no result and leaves the block idle. A tick request searches the key times
// for the current segment, interpolates the two quaternions, normalizes the
// blend and returns one kfq_pkg::result_t on result_valid/result_ready, then
// advances the internal frame counter.
// A tick runs in order: the search reads and compares the time memory one key
// at a time, then a 16-step divider forms t unless t is zero or one, a
// bit-serial square root takes one cycle per root bit and a shared restoring
// divider forms each of the four unit components in turn; the root and the
// divider are skipped when the blend is all zero.
// The key count register is written on cfg_valid/cfg_ready; the user must write
// it only while the block is idle, which the block does not enforce. Reset
// clears the frame counter to zero and sets the key count to one; the key
// memories are not cleared and must be loaded before use. A finished result
// sits in an output register; new requests are accepted while it waits, but
// the next tick stalls at its end until the receiver takes the previous result.
module keyframe_quat_nlerp_to_matrix_top #(
	parameter int MAX_KEYS  = kfq_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kfq_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  kfq_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output kfq_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kfq_pkg::KEY_COUNT_W-1:0]   cfg_data
);
	import kfq_pkg::*;

	localparam int AW  = $clog2(MAX_KEYS);
	localparam int CW  = $clog2(MAX_KEYS + 1);
	localparam int AMW = 34;
	localparam int VW  = 33 - FRAC_BITS;
	localparam int NW  = 2 * VW;
	localparam int RW  = VW;
	localparam int UW  = FRAC_BITS + 2;
	localparam int PW  = 2 * UW;
	localparam int SW  = PW + 1;
	localparam int STW = $clog2(((FRAC_BITS > T_FRAC) ? FRAC_BITS : T_FRAC) + 1);
	localparam logic signed [AMW-1:0] V_BIAS  = AMW'((1 << FRAC_BITS) - 1);
	localparam logic signed [SW-1:0]  TW_BIAS = SW'((1 << (FRAC_BITS - 1)) - 1);
	localparam logic signed [SW:0]    ONE_Q   = (SW+1)'(1 << FRAC_BITS);
	localparam logic [NW-1:0]         SQ_BIT0 = {2'b01, {(NW-2){1'b0}}};

	state_t state_q, state_d;

	logic [KEY_COUNT_W-1:0] key_count_q;
	logic [CW-1:0]          n_cfg;
	logic [TIME_W-1:0]      frame_q, last_q, step100_q, tcur_q, tnxt_q;
	logic [QUAT_PACK_W-1:0] qcur_q, qnxt_q;
	logic [CW-1:0]          i_q;
	logic [AW-1:0]          cur_q, nxt_q;
	logic [T_W-1:0]         t_q;
	logic [TIME_W:0]        trem_q, tden_q;
	logic [STW-1:0]         step_q;
	logic [3:0]             k_q;
	logic signed [VW-1:0]   v_q [4];
	logic [NW-1:0]          sum_q, sqn_q, sqres_q, sqbit_q;
	logic [RW-1:0]          root_q;
	logic [RW:0]            urem_q;
	logic [UW-1:0]          uq_q;
	logic signed [UW-1:0]   u_q [4];
	logic signed [PW-1:0]   prod_q [9];
	logic                   zero_q;
	logic                   result_valid_q;
	result_t                result_q;

	logic                   item_fire, mem_we, out_load;
	logic [AW-1:0]          mem_raddr, mem_waddr;
	logic [TIME_W-1:0]      t_rdata;
	logic [QUAT_PACK_W-1:0] q_rdata;

	always_comb begin
		if (key_count_q == '0) begin
			n_cfg = CW'(1);
		end else if (int'(key_count_q) > MAX_KEYS) begin
			n_cfg = CW'(MAX_KEYS);
		end else begin
			n_cfg = CW'(key_count_q);
		end
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign item_fire    = item_valid && item_ready;
	assign mem_we       = item_fire && (item.op == OP_LOAD) && (int'(item.key_slot) < MAX_KEYS);
	assign mem_waddr    = AW'(item.key_slot);
	assign out_load     = (state_q == ST_DONE) && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		unique case (state_q)
			ST_LAST_RD: mem_raddr = AW'(n_cfg - CW'(1));
			ST_SRCH_RD: mem_raddr = AW'(i_q);
			ST_SEG_CUR: mem_raddr = cur_q;
			ST_SEG_NXT: mem_raddr = nxt_q;
			default:    mem_raddr = '0;
		endcase
	end

	kfq_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_time_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (item.key_frame_time),
		.raddr (mem_raddr),
		.rdata (t_rdata)
	);

	kfq_ram #(.WIDTH(QUAT_PACK_W), .DEPTH(MAX_KEYS)) u_quat_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata ({item.quat_w_in, item.quat_z_in, item.quat_y_in, item.quat_x_in}),
		.raddr (mem_raddr),
		.rdata (q_rdata)
	);

	// Segment search.
	logic          srch_hit, srch_end;
	logic [CW-1:0] cur_sel, nxt_sel;

	always_comb begin
		srch_hit = frame_q < t_rdata;
		srch_end = srch_hit || (i_q == n_cfg - CW'(1));
		if (srch_hit && i_q != '0) begin
			cur_sel = i_q - CW'(1);
		end else begin
			cur_sel = '0;
		end
		if (cur_sel + CW'(1) >= n_cfg) begin
			nxt_sel = '0;
		end else begin
			nxt_sel = cur_sel + CW'(1);
		end
	end

	// Segment fraction.
	logic signed [TIME_W+1:0] seg_num, seg_den;
	logic                     t_zero, t_full, tdiv_ge;
	logic [TIME_W:0]          trem2;

	always_comb begin
		seg_num = $signed({2'b00, frame_q}) - $signed({2'b00, tcur_q});
		seg_den = $signed({2'b00, tnxt_q}) - $signed({2'b00, tcur_q});
		t_zero  = (n_cfg == CW'(1)) || (seg_den <= 0) || (seg_num <= 0);
		t_full  = seg_num >= seg_den;
		trem2   = {trem_q[TIME_W-1:0], 1'b0};
		tdiv_ge = trem2 >= tden_q;
	end

	// Blend, square and normalize.
	logic signed [QUAT_W-1:0] qc_k, qn_k;
	logic signed [T_W:0]      wc, wn;
	logic signed [AMW-1:0]    pc, pn, blend_a, blend_b;
	logic signed [VW-1:0]     v_next, v_k;
	logic signed [NW-1:0]     v_sq;
	logic [NW-1:0]            sum_next, sq_try;
	logic                     sq_ge;
	logic [NW-1:0]            sqres_next;
	logic [RW-1:0]            v_mag;
	logic                     v_neg, u_top;
	logic [RW:0]              urem2;
	logic                     u_ge;
	logic [UW-1:0]            uq_next;

	always_comb begin
		qc_k     = $signed(qcur_q[{k_q[1:0], 4'b0000} +: QUAT_W]);
		qn_k     = $signed(qnxt_q[{k_q[1:0], 4'b0000} +: QUAT_W]);
		wc       = $signed({1'b0, T_W'(T_ONE) - t_q});
		wn       = $signed({1'b0, t_q});
		pc       = AMW'(qc_k * wc);
		pn       = AMW'(qn_k * wn);
		blend_a  = pc + pn;
		blend_b  = blend_a + ((blend_a < 0) ? V_BIAS : '0);
		v_next   = VW'(blend_b >>> FRAC_BITS);
		v_k      = v_q[k_q[1:0]];
		v_sq     = v_k * v_k;
		sum_next = sum_q + NW'($unsigned(v_sq));
		sq_try   = sqres_q + sqbit_q;
		sq_ge    = sqn_q >= sq_try;
		sqres_next = sq_ge ? ((sqres_q >> 1) + sqbit_q) : (sqres_q >> 1);
		v_neg    = v_k[VW-1];
		v_mag    = v_neg ? RW'(-v_k) : RW'(v_k);
		u_top    = v_mag >= root_q;
		urem2    = {urem_q[RW-1:0], 1'b0};
		u_ge     = urem2 >= {1'b0, root_q};
		uq_next  = {uq_q[UW-2:0], u_ge};
	end

	// Products of the unit components: xx yy zz xy zw xz yw yz xw.
	logic signed [UW-1:0] pa, pb;

	always_comb begin
		case (k_q)
			4'd0:    begin pa = u_q[0]; pb = u_q[0]; end
			4'd1:    begin pa = u_q[1]; pb = u_q[1]; end
			4'd2:    begin pa = u_q[2]; pb = u_q[2]; end
			4'd3:    begin pa = u_q[0]; pb = u_q[1]; end
			4'd4:    begin pa = u_q[2]; pb = u_q[3]; end
			4'd5:    begin pa = u_q[0]; pb = u_q[2]; end
			4'd6:    begin pa = u_q[1]; pb = u_q[3]; end
			4'd7:    begin pa = u_q[1]; pb = u_q[2]; end
			4'd8:    begin pa = u_q[0]; pb = u_q[3]; end
			default: begin pa = '0; pb = '0; end
		endcase
	end

	function automatic logic signed [SW:0] twice_sum(
		input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b,
		input logic                 sub
	);
		logic signed [SW-1:0] s;
		logic signed [SW-1:0] sb;
		s  = sub ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
		sb = s + ((s < 0) ? TW_BIAS : '0);
		return (SW+1)'(sb >>> (FRAC_BITS - 1));
	endfunction

	function automatic logic signed [MAT_W-1:0] sat16(input logic signed [SW:0] v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end else if (v < -32768) begin
			return 16'sh8000;
		end else begin
			return MAT_W'(v);
		end
	endfunction

	logic signed [MAT_W-1:0] mat [9];
	logic signed [MAT_W-1:0] one_sat;
	logic [TIME_W:0]         frame_adv;

	always_comb begin
		one_sat = sat16(ONE_Q);
		mat[0] = sat16(ONE_Q - twice_sum(prod_q[1], prod_q[2], 1'b0));
		mat[1] = sat16(twice_sum(prod_q[3], prod_q[4], 1'b0));
		mat[2] = sat16(twice_sum(prod_q[5], prod_q[6], 1'b1));
		mat[3] = sat16(twice_sum(prod_q[3], prod_q[4], 1'b1));
		mat[4] = sat16(ONE_Q - twice_sum(prod_q[0], prod_q[2], 1'b0));
		mat[5] = sat16(twice_sum(prod_q[7], prod_q[8], 1'b0));
		mat[6] = sat16(twice_sum(prod_q[5], prod_q[6], 1'b0));
		mat[7] = sat16(twice_sum(prod_q[7], prod_q[8], 1'b1));
		mat[8] = sat16(ONE_Q - twice_sum(prod_q[0], prod_q[1], 1'b0));
		frame_adv = {1'b0, frame_q} + {1'b0, step100_q};
	end

	logic [DIV100_PW-1:0] d100_prod;
	assign d100_prod = DIV100_PW'(last_q) * DIV100_PW'(DIV100_MUL);

	always_ff @(posedge clk) begin
		step100_q <= TIME_W'(d100_prod >> DIV100_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_fire && item.op == OP_TICK) begin
					state_d = ST_LAST_RD;
				end
			end
			ST_LAST_RD:   state_d = ST_LAST_WT;
			ST_LAST_WT:   state_d = ST_SRCH_RD;
			ST_SRCH_RD:   state_d = ST_SRCH_CMP;
			ST_SRCH_CMP:  state_d = srch_end ? ST_SEG_CUR : ST_SRCH_RD;
			ST_SEG_CUR:   state_d = ST_SEG_NXT;
			ST_SEG_NXT:   state_d = ST_SEG_LATCH;
			ST_SEG_LATCH: state_d = ST_T_SETUP;
			ST_T_SETUP:   state_d = (t_zero || t_full) ? ST_BLEND : ST_T_DIV;
			ST_T_DIV: begin
				if (step_q == STW'(T_FRAC - 1)) begin
					state_d = ST_BLEND;
				end
			end
			ST_BLEND: begin
				if (k_q == 4'd3) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (k_q == 4'd3) begin
					state_d = (sum_next == '0) ? ST_DONE : ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sqbit_q == NW'(1)) begin
					state_d = ST_UDIV_INIT;
				end
			end
			ST_UDIV_INIT: state_d = ST_UDIV_STEP;
			ST_UDIV_STEP: begin
				if (step_q == STW'(FRAC_BITS - 1)) begin
					state_d = (k_q == 4'd3) ? ST_PROD : ST_UDIV_INIT;
				end
			end
			ST_PROD: begin
				if (k_q == 4'd8) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q    <= KEY_COUNT_W'(1);
			frame_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_count_q <= cfg_data;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
				if (frame_adv >= {1'b0, last_q} || frame_adv[TIME_W]) begin
					frame_q <= '0;
				end else begin
					frame_q <= frame_adv[TIME_W-1:0];
				end
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				i_q <= '0;
			end
			ST_LAST_WT: begin
				last_q <= t_rdata;
			end
			ST_SRCH_CMP: begin
				i_q   <= i_q + CW'(1);
				cur_q <= AW'(cur_sel);
				nxt_q <= AW'(nxt_sel);
			end
			ST_SEG_NXT: begin
				tcur_q <= t_rdata;
				qcur_q <= q_rdata;
			end
			ST_SEG_LATCH: begin
				tnxt_q <= t_rdata;
				qnxt_q <= q_rdata;
			end
			ST_T_SETUP: begin
				if (t_zero) begin
					t_q <= '0;
				end else if (t_full) begin
					t_q <= T_W'(T_ONE);
				end else begin
					t_q <= '0;
				end
				trem_q <= seg_num[TIME_W:0];
				tden_q <= seg_den[TIME_W:0];
				step_q <= '0;
				k_q    <= '0;
			end
			ST_T_DIV: begin
				trem_q <= tdiv_ge ? (trem2 - tden_q) : trem2;
				t_q    <= {t_q[T_W-2:0], tdiv_ge};
				step_q <= step_q + STW'(1);
			end
			ST_BLEND: begin
				v_q[k_q[1:0]] <= v_next;
				sum_q         <= '0;
				k_q           <= (k_q == 4'd3) ? 4'd0 : k_q + 4'd1;
			end
			ST_SQUARE: begin
				sum_q   <= sum_next;
				sqn_q   <= sum_next;
				sqres_q <= '0;
				sqbit_q <= SQ_BIT0;
				zero_q  <= (sum_next == '0);
				k_q     <= (k_q == 4'd3) ? 4'd0 : k_q + 4'd1;
			end
			ST_SQRT: begin
				if (sq_ge) begin
					sqn_q <= sqn_q - sq_try;
				end
				sqres_q <= sqres_next;
				sqbit_q <= sqbit_q >> 2;
				root_q  <= RW'(sqres_next);
			end
			ST_UDIV_INIT: begin
				urem_q <= {1'b0, v_mag - (u_top ? root_q : '0)};
				uq_q   <= UW'(u_top);
				step_q <= '0;
			end
			ST_UDIV_STEP: begin
				urem_q <= u_ge ? (urem2 - {1'b0, root_q}) : urem2;
				uq_q   <= uq_next;
				step_q <= step_q + STW'(1);
				if (step_q == STW'(FRAC_BITS - 1)) begin
					u_q[k_q[1:0]] <= v_neg ? -$signed(uq_next) : $signed(uq_next);
					k_q           <= (k_q == 4'd3) ? 4'd0 : k_q + 4'd1;
				end
			end
			ST_PROD: begin
				prod_q[k_q] <= pa * pb;
				k_q         <= k_q + 4'd1;
			end
			ST_DONE: begin
				if (out_load) begin
					if (zero_q) begin
						result_q.m00 <= one_sat;
						result_q.m01 <= '0;
						result_q.m02 <= '0;
						result_q.m10 <= '0;
						result_q.m11 <= one_sat;
						result_q.m12 <= '0;
						result_q.m20 <= '0;
						result_q.m21 <= '0;
						result_q.m22 <= one_sat;
					end else begin
						result_q.m00 <= mat[0];
						result_q.m01 <= mat[1];
						result_q.m02 <= mat[2];
						result_q.m10 <= mat[3];
						result_q.m11 <= mat[4];
						result_q.m12 <= mat[5];
						result_q.m20 <= mat[6];
						result_q.m21 <= mat[7];
						result_q.m22 <= mat[8];
					end
					result_q.frame_used <= frame_q;
					result_q.zero_norm  <= zero_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/kfq_checker.sv =====
module kfq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_ready,
	input kfq_pkg::item_t                  item,
	input logic                            result_valid,
	input logic                            result_ready,
	input kfq_pkg::result_t                result,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [kfq_pkg::KEY_COUNT_W-1:0] cfg_data
);
	import kfq_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
	else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.op == OP_TICK |=> !item_ready)
	else $error("tick request did not block the next request");

	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.op == OP_LOAD && !result_valid |=> !result_valid)
	else $error("load request produced a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_norm |->
			result.m01 == 0 && result.m02 == 0 && result.m10 == 0 && result.m12 == 0 &&
			result.m20 == 0 && result.m21 == 0 &&
			result.m00 == result.m11 && result.m11 == result.m22)
	else $error("zero norm result is not the identity");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
	else $error("configuration write was refused");

endmodule

bind keyframe_quat_nlerp_to_matrix_top kfq_checker u_kfq_checker (.*);

// ===== bench/tb_keyframe_quat_nlerp_to_matrix_top.sv =====
module tb_keyframe_quat_nlerp_to_matrix_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kfq_pkg::*;

	localparam int NKEYS     = MAX_KEYS_DEF;
	localparam int FRAC      = FRAC_BITS_DEF;
	localparam int IDLE_MAX  = 20000;
	localparam int DRAIN_GAP = 400;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [KEY_COUNT_W-1:0] cfg_data;

	keyframe_quat_nlerp_to_matrix_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	item_t pending_requests[$];
	result_t expected_matrices[$];

	logic [TIME_W-1:0] key_time_copy[NKEYS];
	logic signed [QUAT_W-1:0] key_quat_copy[NKEYS][4];
	logic [TIME_W-1:0] frame_copy;
	logic [KEY_COUNT_W-1:0] key_count_copy;

	int err_count;
	int matrices_seen;
	int idle_cycles;
	int send_gap;
	int rx_hold_left;
	bit rx_hold_done;
	int rx_stall_pct;
	int rx_mode_left;
	logic item_fired;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint isqrt(longint n);
		longint res;
		longint b;
		res = 0;
		b = longint'(1) << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [MAT_W-1:0] clamp16(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[MAT_W-1:0];
	endfunction

	function automatic longint dbl(longint p);
		return p / (longint'(1) << (FRAC - 1));
	endfunction

	function automatic result_t evaluate_tick();
		result_t r;
		int n;
		int cur;
		int nxt;
		bit found;
		longint num;
		longint den;
		longint t;
		longint v[4];
		longint u[4];
		longint sum;
		longint rt;
		longint one;
		longint last;
		longint adv;
		longint m[9];
		n = key_count_copy;
		if (n < 1)
			n = 1;
		if (n > NKEYS)
			n = NKEYS;
		cur = 0;
		found = 0;
		for (int i = 0; i < n; i++) begin
			if (!found && frame_copy < key_time_copy[i]) begin
				cur = (i == 0) ? 0 : i - 1;
				found = 1;
			end
		end
		nxt = cur + 1;
		if (nxt >= n)
			nxt = 0;
		num = longint'(frame_copy) - longint'(key_time_copy[cur]);
		den = longint'(key_time_copy[nxt]) - longint'(key_time_copy[cur]);
		if (n == 1 || den <= 0 || num <= 0)
			t = 0;
		else if (num >= den)
			t = 65536;
		else
			t = (num * 65536) / den;
		sum = 0;
		for (int k = 0; k < 4; k++) begin
			v[k] = (longint'(key_quat_copy[cur][k]) * (65536 - t)
				+ longint'(key_quat_copy[nxt][k]) * t) / (longint'(1) << FRAC);
			sum = sum + v[k] * v[k];
		end
		one = longint'(1) << FRAC;
		if (sum == 0) begin
			for (int k = 0; k < 9; k++)
				m[k] = 0;
			m[0] = one;
			m[4] = one;
			m[8] = one;
		end else begin
			rt = isqrt(sum);
			for (int k = 0; k < 4; k++)
				u[k] = (v[k] * one) / rt;
			m[0] = one - dbl(u[1] * u[1] + u[2] * u[2]);
			m[1] = dbl(u[0] * u[1] + u[2] * u[3]);
			m[2] = dbl(u[0] * u[2] - u[1] * u[3]);
			m[3] = dbl(u[0] * u[1] - u[2] * u[3]);
			m[4] = one - dbl(u[0] * u[0] + u[2] * u[2]);
			m[5] = dbl(u[2] * u[1] + u[0] * u[3]);
			m[6] = dbl(u[0] * u[2] + u[1] * u[3]);
			m[7] = dbl(u[1] * u[2] - u[0] * u[3]);
			m[8] = one - dbl(u[0] * u[0] + u[1] * u[1]);
		end
		r.m00 = clamp16(m[0]);
		r.m01 = clamp16(m[1]);
		r.m02 = clamp16(m[2]);
		r.m10 = clamp16(m[3]);
		r.m11 = clamp16(m[4]);
		r.m12 = clamp16(m[5]);
		r.m20 = clamp16(m[6]);
		r.m21 = clamp16(m[7]);
		r.m22 = clamp16(m[8]);
		r.frame_used = frame_copy;
		r.zero_norm = (sum == 0);
		last = key_time_copy[n - 1];
		adv = longint'(frame_copy) + last / 100;
		if (adv >= last || adv > 64'hFFFFFF)
			adv = 0;
		frame_copy = adv[TIME_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		item_fired <= item_valid && item_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				key_count_copy = cfg_data;
			if (item_valid && item_ready) begin
				if (item.op == OP_LOAD) begin
					key_time_copy[item.key_slot] = item.key_frame_time;
					key_quat_copy[item.key_slot][0] = item.quat_x_in;
					key_quat_copy[item.key_slot][1] = item.quat_y_in;
					key_quat_copy[item.key_slot][2] = item.quat_z_in;
					key_quat_copy[item.key_slot][3] = item.quat_w_in;
				end else begin
					expected_matrices.push_back(evaluate_tick());
				end
			end
			if (result_valid && result_ready) begin
				matrices_seen++;
				if (expected_matrices.size() == 0) begin
					$error("Unexpected result with frame_used %0d", result.frame_used);
					err_count++;
				end else begin
					e = expected_matrices.pop_front();
					check_field("m00", e.m00, result.m00);
					check_field("m01", e.m01, result.m01);
					check_field("m02", e.m02, result.m02);
					check_field("m10", e.m10, result.m10);
					check_field("m11", e.m11, result.m11);
					check_field("m12", e.m12, result.m12);
					check_field("m20", e.m20, result.m20);
					check_field("m21", e.m21, result.m21);
					check_field("m22", e.m22, result.m22);
					check_field("frame_used", e.frame_used, result.frame_used);
					check_field("zero_norm", e.zero_norm, result.zero_norm);
				end
			end
			if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_fired)) begin
			if (send_gap > 0) begin
				item_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_requests.size() > 0) begin
				item <= pending_requests.pop_front();
				item_valid <= 1'b1;
				if ($urandom_range(99) < 60)
					send_gap <= 0;
				else if ($urandom_range(99) < 90)
					send_gap <= $urandom_range(4, 1);
				else
					send_gap <= $urandom_range(60, 20);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_mode_left == 0) begin
				rx_mode_left <= $urandom_range(300, 50);
				case ($urandom_range(2))
					0: rx_stall_pct <= 0;
					1: rx_stall_pct <= 25;
					default: rx_stall_pct <= 60;
				endcase
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			if (rx_hold_left > 0) begin
				result_ready <= 1'b0;
				rx_hold_left <= rx_hold_left - 1;
			end else if (!rx_hold_done && matrices_seen >= 120) begin
				result_ready <= 1'b0;
				rx_hold_done <= 1'b1;
				rx_hold_left <= 3000;
			end else if ($urandom_range(999) < 3) begin
				result_ready <= 1'b0;
				rx_hold_left <= $urandom_range(80, 20);
			end else begin
				result_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic item_t load_req(int slot, int tm, int x, int y, int z, int w);
		item_t it;
		it.op = OP_LOAD;
		it.key_slot = SLOT_W'(slot);
		it.key_frame_time = TIME_W'(tm);
		it.quat_x_in = QUAT_W'(x);
		it.quat_y_in = QUAT_W'(y);
		it.quat_z_in = QUAT_W'(z);
		it.quat_w_in = QUAT_W'(w);
		return it;
	endfunction

	function automatic item_t tick_req();
		item_t it;
		it = ($bits(item_t))'({$urandom, $urandom, $urandom});
		it.op = OP_TICK;
		return it;
	endfunction

	function automatic int rand_comp();
		case ($urandom_range(9))
			0: return 0;
			1: return -32768;
			2: return 32767;
			3, 4: return int'($urandom_range(32768)) - 16384;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	task automatic drain();
		wait (pending_requests.size() == 0 && !item_valid);
		wait (expected_matrices.size() == 0);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_key_count(int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= KEY_COUNT_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int random_items;
		int n;
		int cfg_val;
		int tm;
		int step;
		int style;
		int len;
		int slot;
		int times[NKEYS];
		int count_choices[6] = '{2, 64, 0, 127, 1, 7};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		err_count = 0;
		matrices_seen = 0;
		idle_cycles = 0;
		send_gap = 0;
		rx_hold_left = 0;
		rx_hold_done = 0;
		rx_stall_pct = 0;
		rx_mode_left = 0;
		item_fired = 1'b0;
		frame_copy = '0;
		key_count_copy = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_requests.push_back(load_req(0, 0, 0, 0, 0, 0));
		pending_requests.push_back(tick_req());
		pending_requests.push_back(tick_req());
		pending_requests.push_back(load_req(0, 5000, 16384, 0, 0, 0));
		pending_requests.push_back(tick_req());
		pending_requests.push_back(load_req(0, 24'hFFFFFF, -32768, -32768, -32768, -32768));
		pending_requests.push_back(tick_req());
		pending_requests.push_back(load_req(0, 300, 32767, 32767, 32767, 32767));
		pending_requests.push_back(tick_req());
		pending_requests.push_back(tick_req());
		drain();
		write_key_count(2);
		pending_requests.push_back(load_req(0, 10, 0, 0, 0, 16384));
		pending_requests.push_back(load_req(1, 10, 0, 16384, 0, 0));
		pending_requests.push_back(tick_req());
		pending_requests.push_back(load_req(0, 0, 0, 0, 16384, 0));
		pending_requests.push_back(load_req(1, 200, 0, 0, -16384, 0));
		for (int i = 0; i < 6; i++)
			pending_requests.push_back(tick_req());
		drain();

		random_items = 0;
		while (random_items < 600) begin
			cfg_val = ($urandom_range(3) == 0) ? $urandom_range(127)
				: count_choices[$urandom_range(5)];
			write_key_count(cfg_val);
			n = (cfg_val < 1) ? 1 : (cfg_val > NKEYS) ? NKEYS : cfg_val;
			style = $urandom_range(9);
			step = (style < 6) ? $urandom_range(400, 1)
				: (style < 8) ? $urandom_range(200000, 1000) : 0;
			tm = $urandom_range(50);
			for (int i = 0; i < n; i++) begin
				if (style == 9)
					times[i] = (i == n - 1) ? $urandom_range(24'hFFFFFF, 24'hF00000)
						: $urandom_range(24'hFFFFFF);
				else begin
					times[i] = tm;
					if ($urandom_range(7) != 0)
						tm = tm + $urandom_range(step, 0);
					if (tm > 24'hFFFFFF)
						tm = 24'hFFFFFF;
				end
				pending_requests.push_back(load_req(i, times[i], rand_comp(), rand_comp(),
					rand_comp(), rand_comp()));
			end
			len = $urandom_range(110, 40);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0) begin
					slot = $urandom_range(NKEYS - 1);
					if (slot < n)
						tm = times[slot];
					else
						tm = $urandom_range(24'hFFFFFF);
					pending_requests.push_back(load_req(slot, tm, rand_comp(), rand_comp(),
						rand_comp(), rand_comp()));
				end else begin
					pending_requests.push_back(tick_req());
				end
			end
			random_items = random_items + n + len;
			drain();
		end

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
